// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg
// Types and constants shared by the blit rectangle clipper modules.
// ----------------------------------------------------------------------------
package brc_pkg;

   // working width of signed coordinate arithmetic
   localparam int CoordW = 18;

   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;

   localparam logic [CsrAddrW-1:0] REG_SURFACE_WIDTH  = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_SURFACE_HEIGHT = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_CLIP_LEFT      = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_CLIP_TOP       = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_CLIP_SPAN_X    = 3'd4;
   localparam logic [CsrAddrW-1:0] REG_CLIP_SPAN_Y    = 3'd5;

   localparam logic [12:0] SURFACE_RESET = 13'd0;
   localparam logic [15:0] CLIP_POS_RESET = 16'd0;
   localparam logic [14:0] CLIP_SPAN_RESET = 15'd4096;

   localparam logic MODE_FILL = 1'b0;
   localparam logic MODE_COPY = 1'b1;

   // stage advance enables of the per-axis pipeline
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } stage_en_type;

   // effective clip window of one axis: [lo, hi)
   typedef struct packed {
      logic [12:0] lo;
      logic [12:0] hi;
   } clip_axis_type;

   // per-axis results at the end of the axis pipeline
   typedef struct packed {
      logic        fill_ok;
      logic [12:0] fill_pos;
      logic [12:0] fill_len;
      logic        copy_ok;
      logic [12:0] copy_dst;
      logic [12:0] copy_src;
      logic [12:0] copy_len;
   } axis_res_type;

endpackage

// ===== sv/brc_window.sv =====
// ----------------------------------------------------------------------------
// brc_window
// Configuration registers and the registered effective clip window, the
// requested clip rectangle intersected with the destination surface.
// ----------------------------------------------------------------------------
module brc_window #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [brc_pkg::CsrAddrW-1:0]       csr_addr,
   input  logic [brc_pkg::CsrDataW-1:0]       csr_wdata,
   output brc_pkg::clip_axis_type             clip_x,
   output brc_pkg::clip_axis_type             clip_y
);

   localparam logic [14:0] MaxDim = 15'(MAX_DIM);

   logic [12:0] surf_w_ff, surf_w_in;
   logic [12:0] surf_h_ff, surf_h_in;
   logic [15:0] clip_left_ff, clip_left_in;
   logic [15:0] clip_top_ff, clip_top_in;
   logic [14:0] span_x_ff, span_x_in;
   logic [14:0] span_y_ff, span_y_in;
   brc_pkg::clip_axis_type win_x_ff, win_x_in;
   brc_pkg::clip_axis_type win_y_ff, win_y_in;

   logic [12:0] sw_sat, sh_sat;
   logic signed [brc_pkg::CoordW-1:0] left_s, top_s, x0, y0, x1, y1, xe, ye;
   logic signed [brc_pkg::CoordW-1:0] swx, shx;
   logic nonempty;

   always_comb begin
      surf_w_in    = surf_w_ff;
      surf_h_in    = surf_h_ff;
      clip_left_in = clip_left_ff;
      clip_top_in  = clip_top_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      if (csr_we) begin
         case (csr_addr)
            brc_pkg::REG_SURFACE_WIDTH:  surf_w_in    = csr_wdata[12:0];
            brc_pkg::REG_SURFACE_HEIGHT: surf_h_in    = csr_wdata[12:0];
            brc_pkg::REG_CLIP_LEFT:      clip_left_in = csr_wdata;
            brc_pkg::REG_CLIP_TOP:       clip_top_in  = csr_wdata;
            brc_pkg::REG_CLIP_SPAN_X:    span_x_in    = csr_wdata[14:0];
            brc_pkg::REG_CLIP_SPAN_Y:    span_y_in    = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sw_sat = ({2'b00, surf_w_ff} > MaxDim) ? MaxDim[12:0] : surf_w_ff;
      sh_sat = ({2'b00, surf_h_ff} > MaxDim) ? MaxDim[12:0] : surf_h_ff;
      swx    = $signed({5'b0, sw_sat});
      shx    = $signed({5'b0, sh_sat});
      left_s = $signed({{2{clip_left_ff[15]}}, clip_left_ff});
      top_s  = $signed({{2{clip_top_ff[15]}}, clip_top_ff});
      x0     = clip_left_ff[15] ? '0 : left_s;
      y0     = clip_top_ff[15] ? '0 : top_s;
      xe     = left_s + $signed({3'b0, span_x_ff});
      ye     = top_s + $signed({3'b0, span_y_ff});
      x1     = (xe < swx) ? xe : swx;
      y1     = (ye < shx) ? ye : shx;
      nonempty = (x0 < x1) && (y0 < y1);
      // collapse to the empty window at the origin when there is no overlap
      win_x_in.lo = nonempty ? x0[12:0] : '0;
      win_x_in.hi = nonempty ? x1[12:0] : '0;
      win_y_in.lo = nonempty ? y0[12:0] : '0;
      win_y_in.hi = nonempty ? y1[12:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_w_ff    <= brc_pkg::SURFACE_RESET;
         surf_h_ff    <= brc_pkg::SURFACE_RESET;
         clip_left_ff <= brc_pkg::CLIP_POS_RESET;
         clip_top_ff  <= brc_pkg::CLIP_POS_RESET;
         span_x_ff    <= brc_pkg::CLIP_SPAN_RESET;
         span_y_ff    <= brc_pkg::CLIP_SPAN_RESET;
         win_x_ff     <= '0;
         win_y_ff     <= '0;
      end else begin
         surf_w_ff    <= surf_w_in;
         surf_h_ff    <= surf_h_in;
         clip_left_ff <= clip_left_in;
         clip_top_ff  <= clip_top_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         win_x_ff     <= win_x_in;
         win_y_ff     <= win_y_in;
      end
   end

   assign clip_x = win_x_ff;
   assign clip_y = win_y_ff;

endmodule

// ===== sv/brc_axis.sv =====
// ----------------------------------------------------------------------------
// brc_axis
// Three-stage clipping pipeline for one axis. Works out both the fill
// intersection and the copy clamp; the top level picks one by mode.
// ----------------------------------------------------------------------------
module brc_axis #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  brc_pkg::stage_en_type  en,
   input  logic [15:0]            dst_pos,
   input  logic [15:0]            src_pos,
   input  logic [14:0]            len,
   input  logic [12:0]            src_size,
   input  brc_pkg::clip_axis_type clip,
   output brc_pkg::axis_res_type  res
);

   localparam int W = brc_pkg::CoordW;
   localparam logic [14:0] MaxDim = 15'(MAX_DIM);

   // stage 1
   logic signed [W-1:0] d, s, lo, hi, swx;
   logic [12:0] sw;
   logic signed [W-1:0] s1_fx0_ff, s1_fx0_in, s1_fend_ff, s1_fend_in;
   logic signed [W-1:0] s1_hi_ff, s1_hi_in;
   logic [12:0]         s1_w1_ff, s1_w1_in;
   logic                s1_rej_ff, s1_rej_in;
   logic signed [W-1:0] s1_limd_ff, s1_limd_in, s1_lims_ff, s1_lims_in;
   logic signed [W-1:0] s1_offd_ff, s1_offd_in, s1_negs_ff, s1_negs_in;
   logic signed [W-1:0] s1_d_ff, s1_d_in, s1_s_ff, s1_s_in;

   always_comb begin
      d   = $signed({{2{dst_pos[15]}}, dst_pos});
      s   = $signed({{2{src_pos[15]}}, src_pos});
      lo  = $signed({5'b0, clip.lo});
      hi  = $signed({5'b0, clip.hi});
      sw  = ({2'b00, src_size} > MaxDim) ? MaxDim[12:0] : src_size;
      swx = $signed({5'b0, sw});
      s1_fx0_in  = (d > lo) ? d : lo;
      s1_fend_in = d + $signed({3'b0, len});
      s1_hi_in   = hi;
      s1_w1_in   = (len > {2'b00, sw}) ? sw : len[12:0];
      s1_rej_in  = (d >= hi) || (s >= swx);
      s1_limd_in = hi - d;
      s1_lims_in = swx - s;
      s1_offd_in = lo - d;
      s1_negs_in = -s;
      s1_d_in    = d;
      s1_s_in    = s;
   end

   always_ff @(posedge clock) begin
      if (en.en1) begin
         s1_fx0_ff  <= s1_fx0_in;
         s1_fend_ff <= s1_fend_in;
         s1_hi_ff   <= s1_hi_in;
         s1_w1_ff   <= s1_w1_in;
         s1_rej_ff  <= s1_rej_in;
         s1_limd_ff <= s1_limd_in;
         s1_lims_ff <= s1_lims_in;
         s1_offd_ff <= s1_offd_in;
         s1_negs_ff <= s1_negs_in;
         s1_d_ff    <= s1_d_in;
         s1_s_ff    <= s1_s_in;
      end
   end

   // stage 2: far-edge limits and leading offset
   logic signed [W-1:0] w1x, wmin, off0;
   logic signed [W-1:0] s2_fx0_ff, s2_fx0_in, s2_fx1_ff, s2_fx1_in;
   logic signed [W-1:0] s2_w2_ff, s2_w2_in, s2_off_ff, s2_off_in;
   logic                s2_rej_ff, s2_rej_in;
   logic signed [W-1:0] s2_d_ff, s2_d_in, s2_s_ff, s2_s_in;

   always_comb begin
      w1x  = $signed({5'b0, s1_w1_ff});
      wmin = (s1_limd_ff < w1x) ? s1_limd_ff : w1x;
      off0 = (s1_offd_ff > 0) ? s1_offd_ff : '0;
      s2_fx0_in = s1_fx0_ff;
      s2_fx1_in = (s1_fend_ff < s1_hi_ff) ? s1_fend_ff : s1_hi_ff;
      s2_w2_in  = (s1_lims_ff < wmin) ? s1_lims_ff : wmin;
      s2_off_in = (s1_negs_ff > off0) ? s1_negs_ff : off0;
      s2_rej_in = s1_rej_ff;
      s2_d_in   = s1_d_ff;
      s2_s_in   = s1_s_ff;
   end

   always_ff @(posedge clock) begin
      if (en.en2) begin
         s2_fx0_ff <= s2_fx0_in;
         s2_fx1_ff <= s2_fx1_in;
         s2_w2_ff  <= s2_w2_in;
         s2_off_ff <= s2_off_in;
         s2_rej_ff <= s2_rej_in;
         s2_d_ff   <= s2_d_in;
         s2_s_ff   <= s2_s_in;
      end
   end

   // stage 3: final sizes and positions
   logic signed [W-1:0] flen, cdst, csrc, clen;
   brc_pkg::axis_res_type s3_res_ff, s3_res_in;

   always_comb begin
      flen = s2_fx1_ff - s2_fx0_ff;
      cdst = s2_d_ff + s2_off_ff;
      csrc = s2_s_ff + s2_off_ff;
      clen = s2_w2_ff - s2_off_ff;
      s3_res_in.fill_ok  = s2_fx0_ff < s2_fx1_ff;
      s3_res_in.fill_pos = s2_fx0_ff[12:0];
      s3_res_in.fill_len = flen[12:0];
      s3_res_in.copy_ok  = !s2_rej_ff && (s2_off_ff < s2_w2_ff);
      s3_res_in.copy_dst = cdst[12:0];
      s3_res_in.copy_src = csrc[12:0];
      s3_res_in.copy_len = clen[12:0];
   end

   always_ff @(posedge clock) begin
      if (en.en3) begin
         s3_res_ff <= s3_res_in;
      end
   end

   assign res = s3_res_ff;

endmodule

// ===== sv/blit_rect_clipper.sv =====
// ----------------------------------------------------------------------------
// blit_rect_clipper
// Blitter setup stage: clips fill and copy rectangles against the clip window.
// ----------------------------------------------------------------------------
// One request word is taken per clock while req_tready is high, and its
// response word is presented on rsp_tdata after four register stages
// (three per-axis clipping stages plus the output register), the first of
// which loads at the accepting edge itself. Back-pressure on rsp_tready
// stalls the pipeline without loss. A csr write reaches the registered clip
// window through the configuration registers, so req_tready drops for the
// cycle after each write; every request word accepted after the write
// sees the new window. req_tuser carries the mode (0 fill, 1 copy);
// rsp_tuser is the accepted flag and a rejected request returns all-zero
// rsp_tdata.
module blit_rect_clipper #(
   parameter int MAX_DIM = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [brc_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [brc_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // dest_x[15:0] dest_y[31:16] source_x[47:32] source_y[63:48]
   // req_width[78:64] req_height[93:79] source_surface_width[106:94]
   // source_surface_height[119:107]
   input  logic [119:0]                 req_tdata,
   // mode[0]
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_dest_x[12:0] out_dest_y[25:13] out_source_x[38:26]
   // out_source_y[51:39] out_width[64:52] out_height[77:65] top_down[78],
   // zero[79]
   output logic [79:0]                  rsp_tdata,
   // accepted[0]
   output logic                         rsp_tuser
);

   brc_pkg::clip_axis_type clip_x, clip_y;
   brc_pkg::stage_en_type  en;
   brc_pkg::axis_res_type  res_x, res_y;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic csr_hold_ff, csr_hold_in;
   logic en4;

   brc_window #(.MAX_DIM(MAX_DIM)) u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .clip_x    (clip_x),
      .clip_y    (clip_y)
   );

   // advance a stage when it is empty or the one after it moves
   always_comb begin
      en4    = !v4_ff || rsp_tready;
      en.en3 = !v3_ff || en4;
      en.en2 = !v2_ff || en.en3;
      en.en1 = !v1_ff || en.en2;
   end

   // hold off requests while the clip window catches up with a csr write
   assign csr_hold_in = csr_we;
   assign req_tready  = en.en1 && !csr_hold_ff;

   brc_axis #(.MAX_DIM(MAX_DIM)) u_axis_x (
      .clock    (clock),
      .en       (en),
      .dst_pos  (req_tdata[15:0]),
      .src_pos  (req_tdata[47:32]),
      .len      (req_tdata[78:64]),
      .src_size (req_tdata[106:94]),
      .clip     (clip_x),
      .res      (res_x)
   );

   brc_axis #(.MAX_DIM(MAX_DIM)) u_axis_y (
      .clock    (clock),
      .en       (en),
      .dst_pos  (req_tdata[31:16]),
      .src_pos  (req_tdata[63:48]),
      .len      (req_tdata[93:79]),
      .src_size (req_tdata[119:107]),
      .clip     (clip_y),
      .res      (res_y)
   );

   always_comb begin
      v1_in = en.en1 ? (req_tvalid && req_tready) : v1_ff;
      v2_in = en.en2 ? v1_ff : v2_ff;
      v3_in = en.en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      m1_in = en.en1 ? req_tuser : m1_ff;
      m2_in = en.en2 ? m1_ff : m2_ff;
      m3_in = en.en3 ? m2_ff : m3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         csr_hold_ff <= 1'b0;
      end else begin
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
         v4_ff       <= v4_in;
         csr_hold_ff <= csr_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
   end

   // output stage: pick by mode, zero a rejected word
   logic        acc_ff, acc_in;
   logic [79:0] data_ff, data_in;
   logic        fill_ok, copy_ok, td;

   always_comb begin
      fill_ok = res_x.fill_ok && res_y.fill_ok;
      copy_ok = res_x.copy_ok && res_y.copy_ok;
      td      = res_y.copy_dst < res_y.copy_src;
      acc_in  = (m3_ff == brc_pkg::MODE_COPY) ? copy_ok : fill_ok;
      data_in = '0;
      if (acc_in) begin
         if (m3_ff == brc_pkg::MODE_COPY) begin
            data_in = {1'b0, td, res_y.copy_len, res_x.copy_len,
                       res_y.copy_src, res_x.copy_src,
                       res_y.copy_dst, res_x.copy_dst};
         end else begin
            data_in = {1'b0, 1'b0, res_y.fill_len, res_x.fill_len,
                       13'd0, 13'd0, res_y.fill_pos, res_x.fill_pos};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         acc_ff  <= acc_in;
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = acc_ff;

endmodule

// ===== sv/brc_checker.sv =====
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks of the blit rectangle clipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a rejected request carries no coordinates
   `ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 80'd0)

   // an accepted rectangle is never empty and the pad bit stays clear
   `ASSERT_IMPLY(a_accept_size, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata[64:52] != 13'd0) && (rsp_tdata[77:65] != 13'd0) && !rsp_tdata[79])

   // reset drains the pipeline
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind blit_rect_clipper brc_checker u_brc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
